### hw/rtl/tape_bytecode_machine_defines.svh
// Assertion macros for the checker of the tape bytecode machine.
// No dependencies.
`ifndef TAPE_BYTECODE_MACHINE_DEFINES_SVH
`define TAPE_BYTECODE_MACHINE_DEFINES_SVH

// Checked property, switched off while reset is high.
`define TBM_ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tape_bytecode_machine: assertion failed");

// Checked property, also evaluated across reset.
`define TBM_ASSERT(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("tape_bytecode_machine: assertion failed");

`endif

### hw/rtl/tbm_pkg.sv
// Shared types and constants of the tape bytecode machine.
// No dependencies.
package tbm_pkg;

   localparam int BYTE_W = 8;

   localparam logic [BYTE_W-1:0] DP_RESET = 8'h80;

   // transaction kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_STEP = 1'b1;

   // opcodes; anything above OP_SYS halts like OP_HALT
   localparam logic [BYTE_W-1:0] OP_HALT     = 8'd0;
   localparam logic [BYTE_W-1:0] OP_INC_DP   = 8'd1;
   localparam logic [BYTE_W-1:0] OP_DEC_DP   = 8'd2;
   localparam logic [BYTE_W-1:0] OP_INC_CELL = 8'd3;
   localparam logic [BYTE_W-1:0] OP_DEC_CELL = 8'd4;
   localparam logic [BYTE_W-1:0] OP_JZ       = 8'd5;
   localparam logic [BYTE_W-1:0] OP_SYS      = 8'd6;

   // system call selectors (value of the cell under the data pointer)
   localparam logic [BYTE_W-1:0] SYS_READ  = 8'd1;
   localparam logic [BYTE_W-1:0] SYS_WRITE = 8'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_TARGET,
      ST_CELL,
      ST_EMIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              kind;
      logic [BYTE_W-1:0] load_address;
      logic [BYTE_W-1:0] load_data;
      logic [BYTE_W-1:0] input_byte;
   } req_type;

   typedef struct packed {
      logic              halted;
      logic              output_valid;
      logic [BYTE_W-1:0] output_byte;
      logic              input_taken;
      logic [BYTE_W-1:0] instr_pointer;
      logic [BYTE_W-1:0] data_pointer;
   } rsp_type;

endpackage

### hw/rtl/tape_bytecode_machine.sv
// Tape bytecode machine: program and data share one byte store of STORE_DEPTH entries
// (all zero after reset), addressed mod STORE_DEPTH. A load transaction, or any step once
// halted, uses only idle and done; a step adds decode (pointer moves, halt), a cell
// read (cell add/subtract, system call), a target read first (jump) and an emit
// after it (system call that emits a byte): the store has one registered read port,
// and each opcode, jump target and data cell is one read. One request is buffered
// while a step runs and a finished result waits in the output register. Writing the
// CSR also loads the data pointer; do so only while no transaction is in flight.
module tape_bytecode_machine #(
   parameter int STORE_DEPTH = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_kind,
   input  logic [7:0] req_load_address,
   input  logic [7:0] req_load_data,
   input  logic [7:0] req_input_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_halted,
   output logic       rsp_output_valid,
   output logic [7:0] rsp_output_byte,
   output logic       rsp_input_taken,
   output logic [7:0] rsp_instr_pointer,
   output logic [7:0] rsp_data_pointer
);

   localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int BW = tbm_pkg::BYTE_W;

   logic             in_valid_ff, in_valid_in;
   tbm_pkg::req_type in_item_ff, in_item_in;
   logic             rsp_valid_ff, rsp_valid_in;
   tbm_pkg::rsp_type rsp_item_ff, rsp_item_in;

   logic             req_accept;
   logic             item_take;
   logic             out_free;
   logic             rsp_load;
   tbm_pkg::rsp_type core_rsp;

   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr, ram_raddr;
   logic [BW-1:0]    ram_wdata, ram_rdata;

   assign req_stall  = in_valid_ff && !item_take;
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_accept) begin
         in_valid_in             = 1'b1;
         in_item_in.kind         = req_kind;
         in_item_in.load_address = req_load_address;
         in_item_in.load_data    = req_load_data;
         in_item_in.input_byte   = req_input_byte;
      end else if (item_take) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = core_rsp;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   tbm_core #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .item_valid (in_valid_ff),
      .item       (in_item_ff),
      .item_take  (item_take),
      .out_free   (out_free),
      .rsp_load   (rsp_load),
      .rsp        (core_rsp),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata)
   );

   tbm_ram #(
      .WIDTH (BW),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_halted        = rsp_item_ff.halted;
   assign rsp_output_valid  = rsp_item_ff.output_valid;
   assign rsp_output_byte   = rsp_item_ff.output_byte;
   assign rsp_input_taken   = rsp_item_ff.input_taken;
   assign rsp_instr_pointer = rsp_item_ff.instr_pointer;
   assign rsp_data_pointer  = rsp_item_ff.data_pointer;

endmodule

### hw/rtl/tbm_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module tbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/tbm_core.sv
// Instruction sequencer of the tape bytecode machine: fetch, decode,
// read-modify-write of the store. Depends on tbm_pkg; drives a tbm_ram.
module tbm_core #(
   parameter int STORE_DEPTH = 256,
   localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [tbm_pkg::BYTE_W-1:0]  csr_wdata,
   input  logic                        item_valid,
   input  tbm_pkg::req_type            item,
   output logic                        item_take,
   input  logic                        out_free,
   output logic                        rsp_load,
   output tbm_pkg::rsp_type            rsp,
   output logic                        ram_we,
   output logic [IDX_W-1:0]            ram_waddr,
   output logic [tbm_pkg::BYTE_W-1:0]  ram_wdata,
   output logic [IDX_W-1:0]            ram_raddr,
   input  logic [tbm_pkg::BYTE_W-1:0]  ram_rdata
);

   localparam int BW = tbm_pkg::BYTE_W;
   localparam int ADDR_SPAN = 1 << BW;

   tbm_pkg::state_type state_ff, state_in;

   logic [BW-1:0] ip_ff, ip_in;
   logic [BW-1:0] dp_ff, dp_in;
   logic          halt_ff, halt_in;
   logic [BW-1:0] op_ff, op_in;
   logic [BW-1:0] target_ff, target_in;
   logic [BW-1:0] ibyte_ff, ibyte_in;
   logic          ov_ff, ov_in;
   logic [BW-1:0] ob_ff, ob_in;
   logic          taken_ff, taken_in;

   // entries never written read as zero
   logic [STORE_DEPTH-1:0] valid_ff;
   logic                   rvalid_ff;

   logic [BW-1:0] raddr8, waddr8;
   logic [BW-1:0] rd_byte;
   logic [BW-1:0] sys_cell;
   logic          nb_alias;

   // byte address -> store index (address mod depth), fixed at elaboration
   logic [IDX_W-1:0] idx_tab [ADDR_SPAN];

   for (genvar i = 0; i < ADDR_SPAN; i++) begin : g_idx
      assign idx_tab[i] = IDX_W'(i % STORE_DEPTH);
   end

   assign ram_raddr = idx_tab[raddr8];
   assign ram_waddr = idx_tab[waddr8];
   assign rd_byte   = rvalid_ff ? ram_rdata : '0;
   // cell value after a possible read system call
   assign sys_cell  = (rd_byte == tbm_pkg::SYS_READ) ? ibyte_ff : rd_byte;
   // with a depth that divides 255 the neighbor of cell 255 is that cell itself
   assign nb_alias  = (idx_tab[dp_ff + 8'd1] == idx_tab[dp_ff]);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tbm_pkg::ST_IDLE: begin
            if (item_valid) begin
               if (item.kind == tbm_pkg::KIND_STEP && !halt_ff) begin
                  state_in = tbm_pkg::ST_DECODE;
               end else begin
                  state_in = tbm_pkg::ST_DONE;
               end
            end
         end
         tbm_pkg::ST_DECODE: begin
            case (rd_byte)
               tbm_pkg::OP_INC_CELL,
               tbm_pkg::OP_DEC_CELL,
               tbm_pkg::OP_SYS: state_in = tbm_pkg::ST_CELL;
               tbm_pkg::OP_JZ:  state_in = tbm_pkg::ST_TARGET;
               default:         state_in = tbm_pkg::ST_DONE;
            endcase
         end
         tbm_pkg::ST_TARGET: state_in = tbm_pkg::ST_CELL;
         tbm_pkg::ST_CELL: begin
            if (op_ff == tbm_pkg::OP_SYS && sys_cell == tbm_pkg::SYS_WRITE) begin
               state_in = tbm_pkg::ST_EMIT;
            end else begin
               state_in = tbm_pkg::ST_DONE;
            end
         end
         tbm_pkg::ST_EMIT: state_in = tbm_pkg::ST_DONE;
         tbm_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = tbm_pkg::ST_IDLE;
            end
         end
         default: state_in = tbm_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      item_take = 1'b0;
      rsp_load  = 1'b0;
      ram_we    = 1'b0;
      raddr8    = ip_ff;
      waddr8    = dp_ff;
      ram_wdata = '0;
      ip_in     = ip_ff;
      dp_in     = dp_ff;
      halt_in   = halt_ff;
      op_in     = op_ff;
      target_in = target_ff;
      ibyte_in  = ibyte_ff;
      ov_in     = ov_ff;
      ob_in     = ob_ff;
      taken_in  = taken_ff;
      case (state_ff)
         tbm_pkg::ST_IDLE: begin
            if (item_valid) begin
               item_take = 1'b1;
               ov_in     = 1'b0;
               ob_in     = '0;
               taken_in  = 1'b0;
               ibyte_in  = item.input_byte;
               if (item.kind == tbm_pkg::KIND_LOAD) begin
                  ram_we    = 1'b1;
                  waddr8    = item.load_address;
                  ram_wdata = item.load_data;
               end
            end
         end
         tbm_pkg::ST_DECODE: begin
            ip_in = ip_ff + 8'd1;
            op_in = rd_byte;
            case (rd_byte)
               tbm_pkg::OP_INC_DP:   dp_in = dp_ff + 8'd1;
               tbm_pkg::OP_DEC_DP:   dp_in = dp_ff - 8'd1;
               tbm_pkg::OP_INC_CELL,
               tbm_pkg::OP_DEC_CELL,
               tbm_pkg::OP_SYS:      raddr8 = dp_ff;
               tbm_pkg::OP_JZ:       raddr8 = ip_ff + 8'd1;
               default:              halt_in = 1'b1;
            endcase
         end
         tbm_pkg::ST_TARGET: begin
            target_in = rd_byte;
            ip_in     = ip_ff + 8'd1;
            raddr8    = dp_ff;
         end
         tbm_pkg::ST_CELL: begin
            case (op_ff)
               tbm_pkg::OP_INC_CELL: begin
                  ram_we    = 1'b1;
                  ram_wdata = rd_byte + 8'd1;
               end
               tbm_pkg::OP_DEC_CELL: begin
                  ram_we    = 1'b1;
                  ram_wdata = rd_byte - 8'd1;
               end
               tbm_pkg::OP_JZ: begin
                  if (rd_byte == '0) begin
                     ip_in = target_ff;
                  end
               end
               tbm_pkg::OP_SYS: begin
                  if (rd_byte == tbm_pkg::SYS_READ) begin
                     ram_we    = 1'b1;
                     ram_wdata = ibyte_ff;
                     taken_in  = 1'b1;
                  end
                  // neighbor cell for a possible write call
                  raddr8 = dp_ff + 8'd1;
               end
               default: ;
            endcase
         end
         tbm_pkg::ST_EMIT: begin
            ov_in = 1'b1;
            // aliased neighbor is the selector cell, which holds SYS_WRITE by now
            ob_in = nb_alias ? tbm_pkg::SYS_WRITE : rd_byte;
         end
         tbm_pkg::ST_DONE: rsp_load = out_free;
         default: ;
      endcase
      if (csr_we) begin
         dp_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tbm_pkg::ST_IDLE;
         ip_ff    <= '0;
         dp_ff    <= tbm_pkg::DP_RESET;
         halt_ff  <= 1'b0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         ip_ff    <= ip_in;
         dp_ff    <= dp_in;
         halt_ff  <= halt_in;
         if (ram_we) begin
            valid_ff[ram_waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rvalid_ff <= valid_ff[ram_raddr];
      op_ff     <= op_in;
      target_ff <= target_in;
      ibyte_ff  <= ibyte_in;
      ov_ff     <= ov_in;
      ob_ff     <= ob_in;
      taken_ff  <= taken_in;
   end

   assign rsp.halted        = halt_ff;
   assign rsp.output_valid  = ov_ff;
   assign rsp.output_byte   = ob_ff;
   assign rsp.input_taken   = taken_ff;
   assign rsp.instr_pointer = ip_ff;
   assign rsp.data_pointer  = dp_ff;

endmodule

### hw/rtl/tbm_checker.sv
// Port-level checks for tape_bytecode_machine, attached by bind.
// Depends on tape_bytecode_machine_defines.svh.
`include "tape_bytecode_machine_defines.svh"

module tbm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_halted,
   input logic       rsp_output_valid,
   input logic [7:0] rsp_output_byte,
   input logic       rsp_input_taken,
   input logic [7:0] rsp_instr_pointer,
   input logic [7:0] rsp_data_pointer
);

   // a halted result has been delivered; halt only clears on reset
   logic halt_seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         halt_seen_ff <= 1'b0;
      end else if (rsp_valid && !rsp_stall && rsp_halted) begin
         halt_seen_ff <= 1'b1;
      end
   end

   `TBM_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_instr_pointer) && $stable(rsp_data_pointer) && $stable(rsp_output_byte))
   `TBM_ASSERT_RST(a_halt_sticky, clock, reset, rsp_valid && halt_seen_ff |-> rsp_halted)
   `TBM_ASSERT_RST(a_halt_no_io, clock, reset, rsp_valid && rsp_halted |-> !rsp_input_taken && !rsp_output_valid)
   `TBM_ASSERT(a_reset_idle, clock, $past(reset) |-> !rsp_valid)

endmodule

bind tape_bytecode_machine tbm_checker u_tbm_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_halted        (rsp_halted),
   .rsp_output_valid  (rsp_output_valid),
   .rsp_output_byte   (rsp_output_byte),
   .rsp_input_taken   (rsp_input_taken),
   .rsp_instr_pointer (rsp_instr_pointer),
   .rsp_data_pointer  (rsp_data_pointer)
);
